// ===== sv/bwm_pkg.sv =====
package bwm_pkg;

	// Field widths fixed by the interface
	localparam int BASE_W   = 2;
	localparam int CNT_W    = 6;
	localparam int INDEX_W  = 16;
	localparam int STATUS_W = 2;
	localparam int PAT_W    = 64;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 2'd1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_MATCH = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NONE  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SHORT = 2'd2;
	localparam logic [STATUS_W-1:0] ST_LONG  = 2'd3;

	typedef struct packed {
		logic [INDEX_W-1:0]  best_index;
		logic [CNT_W-1:0]    best_matches;
		logic [STATUS_W-1:0] status;
	} result_t;

endpackage

// ===== sv/best_window_match.sv =====
// best_window_match: scores a streamed DNA strand against a probe pattern.
// Input channel: one 2-bit base per beat (in_valid/in_stall), last marks
// the final base of the strand. Output channel: one result beat per
// strand (out_valid/out_stall) with the start of the earliest window with
// the highest match count, that count, and a status code.
// Configuration: cfg_valid/cfg_ready write channel, index 0 loads the
// probe bases, index 1 the probe length. cfg_ready is always high; write
// only between strands.
// Throughput: one base per cycle while in_stall is low. Each cell of
// the window row compares and increments once per beat; the count of
// the window closing that beat is selected and compared with the best
// in the same cycle. Results are registered into a two-entry buffer,
// output register plus skid entry, so the next strand streams in while
// a result is stalled; in_stall rises only when both entries are taken.
// Reset: probe bases clear to zero, length to one, the strand state
// clears, and the result buffer empties. The block accepts bases as soon
// as reset is released.
module best_window_match #(
	parameter int MAX_PATTERN = 32,
	parameter int MAX_STRAND  = 65536
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bwm_pkg::BASE_W-1:0]    base,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bwm_pkg::INDEX_W-1:0]   best_index,
	output logic [bwm_pkg::CNT_W-1:0]     best_matches,
	output logic [bwm_pkg::STATUS_W-1:0]  status,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bwm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bwm_pkg::PAT_W-1:0]     cfg_data
);
	import bwm_pkg::*;

	localparam int SEEN_W = $clog2(MAX_STRAND + 2);
	localparam int SEL_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic [PAT_W-1:0]  pattern_q;
	logic [CNT_W-1:0]  length_q;
	logic [CNT_W-1:0]  len_eff;
	logic [CNT_W-1:0]  len_m1;
	logic [SEEN_W-1:0] seen_q;
	logic [SEEN_W-1:0] seen_next;
	logic [CNT_W-1:0]  best_q;
	logic [CNT_W-1:0]  best_next;
	logic [INDEX_W-1:0] start_q;
	logic [INDEX_W-1:0] start_next;
	logic [CNT_W-1:0]  cnt_q [MAX_PATTERN];
	logic [CNT_W-1:0]  cnt_d [MAX_PATTERN];
	logic [CNT_W-1:0]  cand;
	logic              in_acc;
	logic              scoring;
	logic              win_done;
	logic              push;
	logic              buf_full;
	result_t           res;
	result_t           out_res;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			length_q  <= CNT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PATTERN: pattern_q <= cfg_data;
				REG_LENGTH:  length_q  <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp the probe length into 1..MAX_PATTERN
	always_comb begin
		len_eff = length_q;
		if (length_q == '0) begin
			len_eff = CNT_W'(1);
		end else if (length_q > CNT_W'(MAX_PATTERN)) begin
			len_eff = CNT_W'(MAX_PATTERN);
		end
	end
	assign len_m1 = len_eff - CNT_W'(1);

	assign in_stall = buf_full;
	assign in_acc   = in_valid && !in_stall;
	assign scoring  = in_acc && (seen_q < SEEN_W'(MAX_STRAND));

	// row of window cells, cell k holds the window started k bases ago
	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		logic [CNT_W-1:0] cin;
		if (k == 0) begin : g_head
			assign cin = '0;
		end else begin : g_body
			assign cin = cnt_q[k-1];
		end
		bwm_cell u_cell (
			.clk      (clk),
			.en       (scoring),
			.active   (CNT_W'(k) < len_eff),
			.base     (base),
			.probe    (pattern_q[2*k +: 2]),
			.count_in (cin),
			.count_d  (cnt_d[k]),
			.count_q  (cnt_q[k])
		);
	end

	// window closing this beat and the best-so-far update
	assign cand     = cnt_d[len_m1[SEL_W-1:0]];
	assign win_done = scoring && (seen_q >= SEEN_W'(len_m1));

	always_comb begin
		best_next  = best_q;
		start_next = start_q;
		seen_next  = seen_q;
		if (in_acc) begin
			seen_next = scoring ? (seen_q + SEEN_W'(1)) : SEEN_W'(MAX_STRAND + 1);
		end
		if (win_done && (cand > best_q)) begin
			best_next  = cand;
			start_next = seen_q[INDEX_W-1:0] - INDEX_W'(len_m1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			best_q  <= '0;
			start_q <= '0;
		end else if (in_acc && last) begin
			seen_q  <= '0;
			best_q  <= '0;
			start_q <= '0;
		end else begin
			seen_q  <= seen_next;
			best_q  <= best_next;
			start_q <= start_next;
		end
	end

	// result for the strand ending this beat
	always_comb begin
		res.best_index   = '0;
		res.best_matches = '0;
		if (seen_next > SEEN_W'(MAX_STRAND)) begin
			res.status = ST_LONG;
		end else if (SEEN_W'(len_eff) > seen_next) begin
			res.status = ST_SHORT;
		end else if (best_next == '0) begin
			res.status = ST_NONE;
		end else begin
			res.status       = ST_MATCH;
			res.best_index   = start_next;
			res.best_matches = best_next;
		end
	end

	assign push = in_acc && last;

	bwm_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_res),
		.full      (buf_full)
	);

	assign best_index   = out_res.best_index;
	assign best_matches = out_res.best_matches;
	assign status       = out_res.status;

endmodule

// ===== sv/bwm_cell.sv =====
// One window cell: holds the running match count of the window that
// started k bases ago and hands it to the next cell on each enabled beat.
module bwm_cell (
	input  logic                       clk,
	input  logic                       en,
	input  logic                       active,
	input  logic [bwm_pkg::BASE_W-1:0] base,
	input  logic [bwm_pkg::BASE_W-1:0] probe,
	input  logic [bwm_pkg::CNT_W-1:0]  count_in,
	output logic [bwm_pkg::CNT_W-1:0]  count_d,
	output logic [bwm_pkg::CNT_W-1:0]  count_q
);
	import bwm_pkg::*;

	// count grows when this probe position is in use and matches
	assign count_d = count_in + CNT_W'(active && (probe == base));

	always_ff @(posedge clk) begin
		if (en) begin
			count_q <= count_d;
		end
	end

endmodule

// ===== sv/bwm_outbuf.sv =====
// Two-entry result buffer: output register plus skid entry, so a
// result held by a stalled receiver does not block the base stream.
module bwm_outbuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  bwm_pkg::result_t push_data,
	input  logic             out_stall,
	output logic             out_valid,
	output bwm_pkg::result_t out_data,
	output logic             full
);
	import bwm_pkg::*;

	logic    main_v_q;
	logic    skid_v_q;
	result_t main_q;
	result_t skid_q;
	logic    out_fire;

	assign out_fire  = main_v_q && !out_stall;
	assign out_valid = main_v_q;
	assign out_data  = main_q;
	assign full      = skid_v_q;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!main_v_q || out_fire) begin
			main_v_q <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	// data
	always_ff @(posedge clk) begin
		if (!main_v_q || out_fire) begin
			main_q <= skid_v_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

// ===== sv/bwm_checker.sv =====
// Port-level checks for best_window_match
module bwm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          last,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [bwm_pkg::INDEX_W-1:0]   best_index,
	input logic [bwm_pkg::CNT_W-1:0]     best_matches,
	input logic [bwm_pkg::STATUS_W-1:0]  status
);
	import bwm_pkg::*;

	// input backpressure only when a result is already waiting
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("in_stall without a pending result");

	// a new result beat follows an accepted last base
	a_result_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall && last))
		else $error("result without a preceding last beat");

	// only a found match carries an index and a count
	a_status_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((status == ST_MATCH) ? (best_matches != '0)
			: (best_index == '0 && best_matches == '0)))
		else $error("result fields disagree with status");

	// a stalled result beat stays put
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(best_index)
			&& $stable(best_matches) && $stable(status)))
		else $error("stalled result changed");

endmodule

bind best_window_match bwm_checker u_bwm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.last         (last),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.best_index   (best_index),
	.best_matches (best_matches),
	.status       (status)
);
